### rtl/jdce_pkg.sv
package jdce_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int PAN_W     = 7;
    localparam int TILT_W    = 5;
    localparam int VEL_W     = 7;
    localparam int RAD_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 3;
    localparam int NUM_KINDS = 5;

    localparam int DEF_PAN_LIMIT  = 40;
    localparam int DEF_TILT_LIMIT = 10;
    localparam int DEF_VEL_LIMIT  = 50;
    localparam int DEF_RAD_LIMIT  = 50;

    // dead zone edges and far ends of the high-side ramp
    localparam int PAN_HI_TH   = 540;
    localparam int PAN_HI_END  = 1021;
    localparam int PAN_LO_TH   = 440;
    localparam int TILT_HI_TH  = 555;
    localparam int TILT_HI_END = 1022;
    localparam int TILT_LO_TH  = 425;
    localparam int DRV_HI_TH   = 520;
    localparam int DRV_HI_END  = 1023;
    localparam int DRV_LO_TH   = 480;

    // command byte ranges
    localparam int PAN_BYTE_LO  = 3;
    localparam int PAN_BYTE_HI  = 84;
    localparam int TILT_BYTE_LO = 1;
    localparam int TILT_BYTE_HI = 22;
    localparam int DRV_BYTE_LO  = 1;
    localparam int DRV_BYTE_HI  = 100;

    typedef enum logic [KIND_W-1:0] {
        KIND_LASER = 3'd0,
        KIND_PAN   = 3'd1,
        KIND_TILT  = 3'd2,
        KIND_VEL   = 3'd3,
        KIND_RAD   = 3'd4
    } msg_kind_t;

    typedef struct packed {
        logic                     laser;
        logic signed [PAN_W-1:0]  pan;
        logic signed [TILT_W-1:0] tilt;
        logic signed [VEL_W-1:0]  vel;
        logic signed [RAD_W-1:0]  rad;
    } speed_set_t;

endpackage

### rtl/jdce_ratio.sv
module jdce_ratio #(
    parameter int XW  = 10,
    parameter int QW  = 8,
    parameter int NUM = 1,
    parameter int DEN = 1
) (
    input  logic [XW-1:0] x,
    output logic [QW-1:0] q
);

    // floor(x * NUM / DEN) as one constant multiply and a shift
    localparam int          S  = XW + $clog2(DEN + 1);
    localparam logic [63:0] M  = ((64'(NUM) << S) + 64'(DEN) - 64'd1) / 64'(DEN);
    localparam int          MW = $clog2(M + 64'd1);
    localparam int          PW = XW + MW;

    logic [PW-1:0] prod;

    assign prod = PW'(x) * PW'(M);
    assign q    = QW'(prod >> S);

endmodule

### rtl/jdce_axis.sv
module jdce_axis #(
    parameter int LIMIT  = 40,
    parameter int HI_TH  = 540,
    parameter int HI_END = 1021,
    parameter int LO_TH  = 440,
    parameter int SW     = 7
) (
    input  logic [jdce_pkg::SAMPLE_W-1:0] sample,
    output logic signed [SW-1:0]          speed
);
    import jdce_pkg::*;

    localparam int HI_D = HI_END - HI_TH;
    localparam int MAGW = SW - 1;

    logic                above;
    logic                below;
    logic [SAMPLE_W-1:0] x_hi;
    logic [SAMPLE_W-1:0] x_lo;
    logic [MAGW-1:0]     q_hi;
    logic [MAGW-1:0]     q_lo;

    assign above = sample > SAMPLE_W'(HI_TH);
    assign below = sample < SAMPLE_W'(LO_TH);
    assign x_hi  = sample - SAMPLE_W'(HI_TH);
    assign x_lo  = SAMPLE_W'(LO_TH) - sample;

    jdce_ratio #(
        .XW  (SAMPLE_W),
        .QW  (MAGW),
        .NUM (LIMIT),
        .DEN (HI_D)
    ) u_hi (
        .x (x_hi),
        .q (q_hi)
    );

    jdce_ratio #(
        .XW  (SAMPLE_W),
        .QW  (MAGW),
        .NUM (LIMIT),
        .DEN (LO_TH)
    ) u_lo (
        .x (x_lo),
        .q (q_lo)
    );

    always_comb
    begin
        if (above)
        begin
            speed = -$signed({1'b0, q_hi});
        end
        else if (below)
        begin
            speed = $signed({1'b0, q_lo});
        end
        else
        begin
            speed = '0;
        end
    end

endmodule

### rtl/jdce_seq.sv
module jdce_seq #(
    parameter int PAN_LIMIT  = jdce_pkg::DEF_PAN_LIMIT,
    parameter int TILT_LIMIT = jdce_pkg::DEF_TILT_LIMIT,
    parameter int VEL_LIMIT  = jdce_pkg::DEF_VEL_LIMIT,
    parameter int RAD_LIMIT  = jdce_pkg::DEF_RAD_LIMIT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  jdce_pkg::speed_set_t        speeds,
    output logic                        ready,
    output logic                        msg_valid,
    input  logic                        msg_stall,
    output logic [jdce_pkg::KIND_W-1:0] msg_kind,
    output logic [jdce_pkg::BYTE_W-1:0] msg_value,
    output logic                        last_msg
);
    import jdce_pkg::*;

    logic signed [PAN_W-1:0]  pan_now_reg;
    logic signed [TILT_W-1:0] tilt_now_reg;
    logic signed [VEL_W-1:0]  vel_now_reg;
    logic signed [RAD_W-1:0]  rad_now_reg;

    logic [NUM_KINDS-1:0] mask_reg;
    logic [NUM_KINDS-1:0] mask_next;
    logic [NUM_KINDS-1:0] mask_take;
    logic [BYTE_W-1:0]    value_reg [NUM_KINDS];

    logic [PAN_W-1:0]  pan_u;
    logic [TILT_W-1:0] tilt_u;
    logic [VEL_W-1:0]  vel_u;
    logic [RAD_W-1:0]  rad_u;
    logic [BYTE_W-1:0] pan_q;
    logic [BYTE_W-1:0] tilt_q;
    logic [BYTE_W-1:0] vel_q;
    logic [BYTE_W-1:0] rad_q;

    logic      load_fire;
    logic      take;
    msg_kind_t kind_sel;

    // speed offset to zero at -limit, then scaled into the byte range
    assign pan_u  = $unsigned(speeds.pan) + PAN_W'(PAN_LIMIT);
    assign tilt_u = $unsigned(speeds.tilt) + TILT_W'(TILT_LIMIT);
    assign vel_u  = $unsigned(speeds.vel) + VEL_W'(VEL_LIMIT);
    assign rad_u  = $unsigned(speeds.rad) + RAD_W'(RAD_LIMIT);

    jdce_ratio #(
        .XW  (PAN_W),
        .QW  (BYTE_W),
        .NUM (PAN_BYTE_HI - PAN_BYTE_LO),
        .DEN (2 * PAN_LIMIT - 1)
    ) u_pan_byte (
        .x (pan_u),
        .q (pan_q)
    );

    jdce_ratio #(
        .XW  (TILT_W),
        .QW  (BYTE_W),
        .NUM (TILT_BYTE_HI - TILT_BYTE_LO),
        .DEN (2 * TILT_LIMIT - 1)
    ) u_tilt_byte (
        .x (tilt_u),
        .q (tilt_q)
    );

    jdce_ratio #(
        .XW  (VEL_W),
        .QW  (BYTE_W),
        .NUM (DRV_BYTE_HI - DRV_BYTE_LO),
        .DEN (2 * VEL_LIMIT - 1)
    ) u_vel_byte (
        .x (vel_u),
        .q (vel_q)
    );

    jdce_ratio #(
        .XW  (RAD_W),
        .QW  (BYTE_W),
        .NUM (DRV_BYTE_HI - DRV_BYTE_LO),
        .DEN (2 * RAD_LIMIT - 1)
    ) u_rad_byte (
        .x (rad_u),
        .q (rad_q)
    );

    assign mask_take = mask_reg & (mask_reg - NUM_KINDS'(1));
    assign msg_valid = |mask_reg;
    assign last_msg  = (mask_take == '0);
    assign take      = msg_valid && !msg_stall;
    assign ready     = !msg_valid || (take && last_msg);
    assign load_fire = load && ready;

    // lowest pending kind goes out first
    always_comb
    begin
        kind_sel = KIND_LASER;
        for (int i = NUM_KINDS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                kind_sel = msg_kind_t'(i);
            end
        end
    end

    assign msg_kind  = kind_sel;
    assign msg_value = value_reg[kind_sel];

    always_comb
    begin
        mask_next = mask_reg;
        if (load_fire)
        begin
            mask_next             = '0;
            mask_next[KIND_LASER] = 1'b1;
            mask_next[KIND_PAN]   = speeds.pan != pan_now_reg;
            mask_next[KIND_TILT]  = speeds.tilt != tilt_now_reg;
            mask_next[KIND_VEL]   = speeds.vel != vel_now_reg;
            mask_next[KIND_RAD]   = speeds.rad != rad_now_reg;
        end
        else if (take)
        begin
            mask_next = mask_take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            pan_now_reg  <= '0;
            tilt_now_reg <= '0;
            vel_now_reg  <= '0;
            rad_now_reg  <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (load_fire)
            begin
                pan_now_reg  <= speeds.pan;
                tilt_now_reg <= speeds.tilt;
                vel_now_reg  <= speeds.vel;
                rad_now_reg  <= speeds.rad;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            value_reg[KIND_LASER] <= BYTE_W'(speeds.laser);
            value_reg[KIND_PAN]   <= BYTE_W'(PAN_BYTE_LO) + pan_q;
            value_reg[KIND_TILT]  <= BYTE_W'(TILT_BYTE_LO) + tilt_q;
            value_reg[KIND_VEL]   <= BYTE_W'(DRV_BYTE_LO) + vel_q;
            value_reg[KIND_RAD]   <= BYTE_W'(DRV_BYTE_LO) + rad_q;
        end
    end

endmodule

### rtl/joystick_deadzone_command_encoder.sv
// A sample set (four stick axes and the active-low fire pin) passes an input
// register, a speed register and a message register before its first word
// is on the port. Each sample yields a laser word plus one word for every
// axis whose speed changed, in the order laser, pan, tilt, velocity, radius;
// last_msg marks the final word of a sample. The single message port sends
// one word per cycle while msg_stall is low, so a sample takes one to five
// words; samples that change no speed flow at one per cycle while the port
// is not stalled.
module joystick_deadzone_command_encoder #(
    parameter int PAN_LIMIT  = jdce_pkg::DEF_PAN_LIMIT,
    parameter int TILT_LIMIT = jdce_pkg::DEF_TILT_LIMIT,
    parameter int VEL_LIMIT  = jdce_pkg::DEF_VEL_LIMIT,
    parameter int RAD_LIMIT  = jdce_pkg::DEF_RAD_LIMIT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [jdce_pkg::SAMPLE_W-1:0] stick1_x,
    input  logic [jdce_pkg::SAMPLE_W-1:0] stick1_y,
    input  logic [jdce_pkg::SAMPLE_W-1:0] stick2_x,
    input  logic [jdce_pkg::SAMPLE_W-1:0] stick2_y,
    input  logic                          fire_pin_level,
    output logic                          msg_valid,
    input  logic                          msg_stall,
    output logic [jdce_pkg::KIND_W-1:0]   msg_kind,
    output logic [jdce_pkg::BYTE_W-1:0]   msg_value,
    output logic                          last_msg
);
    import jdce_pkg::*;

    logic                a_valid_reg;
    logic                a_valid_next;
    logic [SAMPLE_W-1:0] a_s1x_reg;
    logic [SAMPLE_W-1:0] a_s1y_reg;
    logic [SAMPLE_W-1:0] a_s2x_reg;
    logic [SAMPLE_W-1:0] a_s2y_reg;
    logic                a_fire_reg;

    logic       b_valid_reg;
    logic       b_valid_next;
    speed_set_t b_speeds_reg;
    speed_set_t a_speeds;

    logic sample_take;
    logic a_adv;
    logic seq_ready;

    assign a_adv        = !b_valid_reg || seq_ready;
    assign sample_stall = a_valid_reg && !a_adv;
    assign sample_take  = sample_valid && !sample_stall;

    jdce_axis #(
        .LIMIT  (PAN_LIMIT),
        .HI_TH  (PAN_HI_TH),
        .HI_END (PAN_HI_END),
        .LO_TH  (PAN_LO_TH),
        .SW     (PAN_W)
    ) u_pan (
        .sample (a_s1y_reg),
        .speed  (a_speeds.pan)
    );

    jdce_axis #(
        .LIMIT  (TILT_LIMIT),
        .HI_TH  (TILT_HI_TH),
        .HI_END (TILT_HI_END),
        .LO_TH  (TILT_LO_TH),
        .SW     (TILT_W)
    ) u_tilt (
        .sample (a_s1x_reg),
        .speed  (a_speeds.tilt)
    );

    jdce_axis #(
        .LIMIT  (VEL_LIMIT),
        .HI_TH  (DRV_HI_TH),
        .HI_END (DRV_HI_END),
        .LO_TH  (DRV_LO_TH),
        .SW     (VEL_W)
    ) u_vel (
        .sample (a_s2x_reg),
        .speed  (a_speeds.vel)
    );

    jdce_axis #(
        .LIMIT  (RAD_LIMIT),
        .HI_TH  (DRV_HI_TH),
        .HI_END (DRV_HI_END),
        .LO_TH  (DRV_LO_TH),
        .SW     (RAD_W)
    ) u_rad (
        .sample (a_s2y_reg),
        .speed  (a_speeds.rad)
    );

    assign a_speeds.laser = ~a_fire_reg;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (sample_take)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
        b_valid_next = a_adv ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            a_s1x_reg  <= stick1_x;
            a_s1y_reg  <= stick1_y;
            a_s2x_reg  <= stick2_x;
            a_s2y_reg  <= stick2_y;
            a_fire_reg <= fire_pin_level;
        end
        if (a_adv)
        begin
            b_speeds_reg <= a_speeds;
        end
    end

    jdce_seq #(
        .PAN_LIMIT  (PAN_LIMIT),
        .TILT_LIMIT (TILT_LIMIT),
        .VEL_LIMIT  (VEL_LIMIT),
        .RAD_LIMIT  (RAD_LIMIT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (b_valid_reg),
        .speeds    (b_speeds_reg),
        .ready     (seq_ready),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_kind  (msg_kind),
        .msg_value (msg_value),
        .last_msg  (last_msg)
    );

    // a new sample always opens with its laser word
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && !msg_stall && last_msg) |=>
            (!msg_valid || msg_kind == KIND_LASER))
        else $error("sample did not start with laser word");

    // words of one sample follow without gaps in rising kind order
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && !msg_stall && !last_msg) |=>
            (msg_valid && msg_kind > $past(msg_kind)))
        else $error("word sequence broken within a sample");

    // laser word carries only on/off
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && msg_kind == KIND_LASER) |-> (msg_value <= BYTE_W'(1)))
        else $error("laser word out of range");

    // a stalled sample slot means the speed stage is still occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (b_valid_reg && msg_valid))
        else $error("input stalled with free pipeline");

endmodule
